/* rtl/postfix_stack_evaluator_defines.svh */
// ----------------------------------------------------------------------------
// Postfix stack evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PSE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define PSE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/pse_pkg.sv */
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Widths, constants, command and operation codes, control types.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam logic [DATA_W-1:0] INT_MIN   = 32'h8000_0000;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_REM  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_REM
  } alu_op_e;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_RUN,
    AS_FIX,
    AS_DONE
  } alu_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_EXEC,
    CS_FIN
  } ctl_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

/* rtl/pse_if.sv */
// ----------------------------------------------------------------------------
// Postfix stack evaluator channels
// Token request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pse_tok_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] operand_value;
  logic               last_token;

  modport source (output valid, output command, output operand_value,
                  output last_token, input ready);
  modport sink   (input valid, input command, input operand_value,
                  input last_token, output ready);
endinterface

interface pse_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

/* rtl/postfix_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Takes postfix tokens on tok_i and returns the top of stack and status on
// res_o for each token marked last_token.
// Usage:
//   tok_i carries one token per request: push an operand or apply an
//   operator (add, subtract, multiply, divide, remainder) to the top two.
//   tok_i.ready is high only while the sequencer is idle.
//   Push and unused commands finish in the idle state; the operators load
//   the stack, then run in the arithmetic unit, where multiply, divide and
//   remainder iterate on its shared adder. A last token passes through a
//   final step before its result is loaded into the output register.
//   res_o is registered: a pending result does not block later tokens, but a
//   further last token waits in its final step while res_o is stalled.
//   Reset empties the stack and clears the error flag; stack memory contents
//   are not cleared, only entries below the count are ever used.
// ----------------------------------------------------------------------------
`include "postfix_stack_evaluator_defines.svh"

module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pse_tok_if.sink   tok_i,
  pse_res_if.source res_o
);
  import pse_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  ctl_state_e        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              error_q, error_d;
  logic [DATA_W-1:0] top_q, top_d;
  cmd_e              cmd_q, cmd_d;
  logic              last_q, last_d;
  logic              oval_q, oval_d;
  logic [DATA_W-1:0] ores_q, ores_d;
  logic              osts_q, osts_d;

  logic              accept;
  logic              full;
  logic [CW-1:0]     base;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [DATA_W-1:0] alu_a, alu_b, alu_res;

  assign tok_i.ready = (state_q == CS_IDLE);
  assign accept      = tok_i.valid && tok_i.ready;
  assign full        = (count_q == CW'(STACK_DEPTH));
  assign base        = (count_q >= CW'(2)) ? (count_q - CW'(2)) : '0;

  pse_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  pse_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .rsp_o   (alu_rsp),
    .result_o(alu_res)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    error_d     = error_q;
    top_d       = top_q;
    cmd_d       = cmd_q;
    last_d      = last_q;
    oval_d      = oval_q && !res_o.ready;
    ores_d      = ores_q;
    osts_d      = osts_q;
    we          = 1'b0;
    waddr       = AW'(count_q);
    wdata       = tok_i.operand_value;
    re          = 1'b0;
    raddr       = AW'(count_q - CW'(2));
    alu_req     = '{start: 1'b0, op: ALU_ADD};
    alu_a       = (count_q >= CW'(2)) ? rdata : INT_MIN;
    alu_b       = (count_q != '0) ? top_q : INT_MIN;
    case (state_q)
      CS_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_e'(tok_i.command);
          last_d = tok_i.last_token;
          case (tok_i.command) inside
            CMD_PUSH: begin
              if (!full) begin
                we      = 1'b1;
                top_d   = tok_i.operand_value;
                count_d = count_q + 1'b1;
              end
              state_d = tok_i.last_token ? CS_FIN : CS_IDLE;
            end
            [CMD_ADD:CMD_REM]: begin
              re      = 1'b1;
              state_d = CS_LOAD;
            end
            default: begin
              state_d = tok_i.last_token ? CS_FIN : CS_IDLE;
            end
          endcase
        end
      end
      CS_LOAD: begin
        alu_req.start = 1'b1;
        case (cmd_q)
          CMD_SUB: alu_req.op = ALU_SUB;
          CMD_MUL: alu_req.op = ALU_MUL;
          CMD_DIV: alu_req.op = ALU_DIV;
          CMD_REM: alu_req.op = ALU_REM;
          default: alu_req.op = ALU_ADD;
        endcase
        state_d = CS_EXEC;
      end
      CS_EXEC: begin
        if (alu_rsp.done) begin
          we      = 1'b1;
          waddr   = AW'(base);
          wdata   = alu_res;
          top_d   = alu_res;
          count_d = base + 1'b1;
          error_d = error_q | alu_rsp.div_zero;
          state_d = last_q ? CS_FIN : CS_IDLE;
        end
      end
      CS_FIN: begin
        if (!oval_q || res_o.ready) begin
          oval_d  = 1'b1;
          ores_d  = (count_q == '0) ? INT_MIN : top_q;
          osts_d  = error_q;
          count_d = '0;
          error_d = 1'b0;
          state_d = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      count_q <= '0;
      error_q <= 1'b0;
      oval_q  <= 1'b0;
      cmd_q   <= CMD_PUSH;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      error_q <= error_d;
      oval_q  <= oval_d;
      cmd_q   <= cmd_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    ores_q <= ores_d;
    osts_q <= osts_d;
  end

  assign res_o.valid        = oval_q;
  assign res_o.result_value = ores_q;
  assign res_o.status       = osts_q;

  `PSE_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(STACK_DEPTH), "stack count over depth")
  `PSE_ASSERT_ALWAYS(a_done_in_exec, !alu_rsp.done || state_q == CS_EXEC, "alu done outside exec")
  `PSE_ASSERT_NEXT(a_fin_clears, state_q == CS_FIN && (!oval_q || res_o.ready),
                   count_q == '0 && !error_q && oval_q, "final step did not clear")

endmodule

/* rtl/pse_stack.sv */
// ----------------------------------------------------------------------------
// Operand stack memory
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module pse_stack #(
  parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]        waddr_i,
  input  logic [pse_pkg::DATA_W-1:0]            wdata_i,
  input  logic                                  re_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]        raddr_i,
  output logic [pse_pkg::DATA_W-1:0]            rdata_o
);
  import pse_pkg::*;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pse_alu.sv */
// ----------------------------------------------------------------------------
// Iterative arithmetic unit
// Add and subtract in one step; shift-add multiply and restoring signed
// divide/remainder share one 33-bit adder over DATA_W iterations.
// ----------------------------------------------------------------------------
module pse_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pse_pkg::alu_req_t          req_i,
  input  logic [pse_pkg::DATA_W-1:0] a_i,
  input  logic [pse_pkg::DATA_W-1:0] b_i,
  output pse_pkg::alu_rsp_t          rsp_o,
  output logic [pse_pkg::DATA_W-1:0] result_o
);
  import pse_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_W);

  alu_state_e        state_q, state_d;
  alu_op_e           op_q, op_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] bmag_q, bmag_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic              nega_q, nega_d;
  logic              negb_q, negb_d;
  logic              dz_q, dz_d;

  logic              sub;
  logic [DATA_W:0]   add_x, add_y, add_sum;

  // shared adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    sub     = (op_q != ALU_MUL);
    add_x   = sub ? {acc_q, quo_q[DATA_W-1]} : {1'b0, acc_q};
    add_y   = {1'b0, bmag_q};
    add_sum = add_x + (sub ? ~add_y : add_y) + {{DATA_W{1'b0}}, sub};
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    bmag_d  = bmag_q;
    res_d   = res_q;
    nega_d  = nega_q;
    negb_d  = negb_q;
    dz_d    = dz_q;
    case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          dz_d  = 1'b0;
          cnt_d = CntW'(DATA_W - 1);
          acc_d = '0;
          case (req_i.op)
            ALU_ADD: begin
              res_d   = a_i + b_i;
              state_d = AS_DONE;
            end
            ALU_SUB: begin
              res_d   = a_i - b_i;
              state_d = AS_DONE;
            end
            ALU_MUL: begin
              bmag_d  = a_i;
              quo_d   = b_i;
              state_d = AS_RUN;
            end
            default: begin
              if (b_i == '0) begin
                res_d   = '0;
                dz_d    = 1'b1;
                state_d = AS_DONE;
              end else begin
                nega_d  = a_i[DATA_W-1];
                negb_d  = b_i[DATA_W-1];
                quo_d   = a_i[DATA_W-1] ? (~a_i + 1'b1) : a_i;
                bmag_d  = b_i[DATA_W-1] ? (~b_i + 1'b1) : b_i;
                state_d = AS_RUN;
              end
            end
          endcase
        end
      end
      AS_RUN: begin
        if (op_q == ALU_MUL) begin
          if (quo_q[0]) begin
            acc_d = add_sum[DATA_W-1:0];
          end
          bmag_d = {bmag_q[DATA_W-2:0], 1'b0};
          quo_d  = {1'b0, quo_q[DATA_W-1:1]};
        end else if (!add_sum[DATA_W]) begin
          acc_d = add_sum[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          acc_d = add_x[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = AS_FIX;
        end
      end
      AS_FIX: begin
        case (op_q)
          ALU_MUL: res_d = acc_q;
          ALU_REM: res_d = nega_q ? (~acc_q + 1'b1) : acc_q;
          default: res_d = (nega_q ^ negb_q) ? (~quo_q + 1'b1) : quo_q;
        endcase
        state_d = AS_DONE;
      end
      AS_DONE: begin
        state_d = AS_IDLE;
      end
      default: begin
        state_d = AS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      cnt_q   <= '0;
      dz_q    <= 1'b0;
      op_q    <= ALU_ADD;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dz_q    <= dz_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    bmag_q <= bmag_d;
    res_q  <= res_d;
    nega_q <= nega_d;
    negb_q <= negb_d;
  end

  assign rsp_o.done     = (state_q == AS_DONE);
  assign rsp_o.div_zero = dz_q;
  assign result_o       = res_q;

endmodule
